### hw/rtl/sifd_pkg.sv
// Package for the smart integer field decoder.
// Holds item structs, decoder state struct, field kind codes and constants.
// No dependencies.
`default_nettype none

package sifd_pkg;

    localparam logic [3:0] KIND_U8     = 4'd0;
    localparam logic [3:0] KIND_S8     = 4'd1;
    localparam logic [3:0] KIND_U16    = 4'd2;
    localparam logic [3:0] KIND_S16    = 4'd3;
    localparam logic [3:0] KIND_U24    = 4'd4;
    localparam logic [3:0] KIND_S32    = 4'd5;
    localparam logic [3:0] KIND_S64    = 4'd6;
    localparam logic [3:0] KIND_SSMART = 4'd7;
    localparam logic [3:0] KIND_BSMART = 4'd8;
    localparam logic [3:0] KIND_XSMART = 4'd9;

    localparam logic [31:0] RUN_MARK    = 32'd32767;
    localparam logic [31:0] SUM_MAX     = 32'h7fff_ffff;
    localparam logic [63:0] SMART_BIAS  = 64'h8000;
    localparam logic [63:0] BIG_THRESH  = 64'h8000_0000;
    localparam logic [7:0]  LONG_FIRST  = 8'd128;

    typedef struct packed {
        logic [7:0] in_byte;
        logic [3:0] mode;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] value;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic        in_field;
        logic [3:0]  field_kind;
        logic [2:0]  bytes_left;
        logic [63:0] partial_value;
        logic [31:0] extended_sum;
        logic        sum_clamped;
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/smart_integer_field_decoder_unit.sv
// Smart integer field decoder: input register, one decode step, result register.
// A field's result is registered as its last byte leaves the input register.
// Throughput: one byte per cycle while no waiting result stalls the decode step.
// Reset (synchronous, active low) empties both registers and clears the field state.
// Depends on sifd_pkg and sifd_step.
`default_nettype none

module smart_integer_field_decoder_unit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire sifd_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output sifd_pkg::t_out_item      o_out_item
);

    logic                r_in_valid;
    sifd_pkg::t_in_item  r_in;
    sifd_pkg::t_state    r_state;
    logic                r_out_valid;
    sifd_pkg::t_out_item r_out;

    sifd_pkg::t_state    n_state;
    logic                res_valid;
    sifd_pkg::t_out_item res;
    logic                consume;

    sifd_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // advance the held byte unless its result would overwrite a waiting one
    assign consume    = r_in_valid && (!res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### hw/rtl/sifd_step.sv
// Combinational decode step of the smart integer field decoder.
// Takes the current state and one byte, gives the next state and the result.
// Depends on sifd_pkg.
`default_nettype none

module sifd_step (
    input  wire sifd_pkg::t_state    i_state,
    input  wire sifd_pkg::t_in_item  i_item,
    output sifd_pkg::t_state         o_state,
    output logic                     o_res_valid,
    output sifd_pkg::t_out_item      o_res
);

    logic        first;
    logic [3:0]  kind;
    logic [31:0] esum;
    logic        clamp;
    logic [2:0]  len_m1;
    logic [63:0] p;
    logic [2:0]  bl;
    logic [63:0] ss_val;
    logic [31:0] s32;
    logic [31:0] t_sum;
    logic [31:0] t_sat;
    logic        t_over;

    always_comb begin
        first = !i_state.in_field || (i_state.bytes_left == 3'd0);
        if (!i_state.in_field) begin
            kind  = (i_item.mode > sifd_pkg::KIND_XSMART) ? sifd_pkg::KIND_U8 : i_item.mode;
            esum  = 32'd0;
            clamp = 1'b0;
        end else begin
            kind  = i_state.field_kind;
            esum  = i_state.extended_sum;
            clamp = i_state.sum_clamped;
        end

        // byte count minus one of the field starting here
        unique case (kind)
            sifd_pkg::KIND_U8,
            sifd_pkg::KIND_S8:  len_m1 = 3'd0;
            sifd_pkg::KIND_U16,
            sifd_pkg::KIND_S16: len_m1 = 3'd1;
            sifd_pkg::KIND_U24: len_m1 = 3'd2;
            sifd_pkg::KIND_S32: len_m1 = 3'd3;
            sifd_pkg::KIND_S64: len_m1 = 3'd7;
            sifd_pkg::KIND_BSMART:
                len_m1 = (i_item.in_byte >= sifd_pkg::LONG_FIRST) ? 3'd3 : 3'd1;
            default:
                len_m1 = (i_item.in_byte < sifd_pkg::LONG_FIRST) ? 3'd0 : 3'd1;
        endcase

        if (first) begin
            p  = {56'd0, i_item.in_byte};
            bl = len_m1;
        end else begin
            p  = {i_state.partial_value[55:0], i_item.in_byte};
            bl = i_state.bytes_left - 3'd1;
        end

        ss_val = (p >= sifd_pkg::SMART_BIAS) ? (p - sifd_pkg::SMART_BIAS) : p;
        s32    = ss_val[31:0];
        t_sum  = esum + s32;
        t_over = (t_sum > sifd_pkg::SUM_MAX);
        t_sat  = t_over ? sifd_pkg::SUM_MAX : t_sum;

        o_state.field_kind    = kind;
        o_state.partial_value = p;
        o_state.extended_sum  = esum;
        o_state.sum_clamped   = clamp;
        o_state.bytes_left    = bl;
        o_state.in_field      = 1'b1;
        o_res_valid           = 1'b0;
        o_res.value           = 64'sd0;
        o_res.saturated       = 1'b0;

        if (bl == 3'd0) begin
            o_state.in_field = 1'b0;
            o_res_valid      = 1'b1;
            unique case (kind)
                sifd_pkg::KIND_U8:  o_res.value = {56'd0, p[7:0]};
                sifd_pkg::KIND_S8:  o_res.value = {{56{p[7]}}, p[7:0]};
                sifd_pkg::KIND_U16: o_res.value = {48'd0, p[15:0]};
                sifd_pkg::KIND_S16: o_res.value = {{48{p[15]}}, p[15:0]};
                sifd_pkg::KIND_U24: o_res.value = {40'd0, p[23:0]};
                sifd_pkg::KIND_S32: o_res.value = {{32{p[31]}}, p[31:0]};
                sifd_pkg::KIND_S64: o_res.value = p;
                sifd_pkg::KIND_SSMART: o_res.value = ss_val;
                sifd_pkg::KIND_BSMART: begin
                    if (p >= sifd_pkg::BIG_THRESH) begin
                        o_res.value = {33'd0, p[30:0]};
                    end else if (p == {32'd0, sifd_pkg::RUN_MARK}) begin
                        o_res.value = -64'sd1;
                    end else begin
                        o_res.value = p;
                    end
                end
                default: begin
                    // extended run: accumulate, hold the field open on the mark
                    o_state.extended_sum = t_sat;
                    o_state.sum_clamped  = clamp | t_over;
                    if (s32 == sifd_pkg::RUN_MARK) begin
                        o_state.in_field = 1'b1;
                        o_res_valid      = 1'b0;
                    end
                    o_res.value     = {32'd0, t_sat};
                    o_res.saturated = clamp | t_over;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### tb/tb_smart_integer_field_decoder_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for smart_integer_field_decoder_unit: byte stream in,
// decoded field values out, checked against an in-bench decoder model.
// Depends on sifd_pkg and the decoder RTL.

module tb_smart_integer_field_decoder_unit;

    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 20;

    typedef struct {
        logic [7:0]  b;
        logic [3:0]  m;
        bit          typed;
        logic [63:0] v;
        bit          sat;
    } t_dir_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    sifd_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sifd_pkg::t_out_item out_item;

    smart_integer_field_decoder_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Decoder model state
    logic        dec_in_field = 1'b0;
    logic [3:0]  dec_kind     = sifd_pkg::KIND_U8;
    logic [2:0]  dec_left     = 3'd0;
    logic [63:0] dec_partial  = '0;
    logic [31:0] dec_sum      = '0;
    logic        dec_clamped  = 1'b0;

    sifd_pkg::t_out_item expected_fields[$];
    t_dir_row            dir_rows[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  bytes_sent    = 0;
    int  fields_seen   = 0;
    int  clamped_seen  = 0;
    int  mismatches    = 0;
    bit  hold_req      = 1'b0;
    bit  hold_done     = 1'b0;
    int  hold_count    = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("timeout: %0d fields still expected", expected_fields.size());
        $display("smart_integer_field_decoder_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR %s: got %h, expected %h", what, got, want);
    endtask

    // Advance the decoder model by one byte; done is set when a field completes.
    task automatic advance_decoder(input sifd_pkg::t_in_item it, output bit done,
                                   output sifd_pkg::t_out_item res);
        logic [3:0]  len;
        logic [63:0] p;
        logic [63:0] v;
        logic [31:0] s;
        logic [31:0] t;
        done = 1'b0;
        res  = '0;
        v    = '0;
        if (!dec_in_field) begin
            dec_kind    = (it.mode > sifd_pkg::KIND_XSMART) ? sifd_pkg::KIND_U8 : it.mode;
            dec_sum     = '0;
            dec_clamped = 1'b0;
        end
        if (!dec_in_field || dec_left == 3'd0) begin
            case (dec_kind)
                sifd_pkg::KIND_U8, sifd_pkg::KIND_S8:   len = 4'd1;
                sifd_pkg::KIND_U16, sifd_pkg::KIND_S16: len = 4'd2;
                sifd_pkg::KIND_U24:                     len = 4'd3;
                sifd_pkg::KIND_S32:                     len = 4'd4;
                sifd_pkg::KIND_S64:                     len = 4'd8;
                sifd_pkg::KIND_BSMART:
                    len = (it.in_byte >= sifd_pkg::LONG_FIRST) ? 4'd4 : 4'd2;
                default:
                    len = (it.in_byte < sifd_pkg::LONG_FIRST) ? 4'd1 : 4'd2;
            endcase
            dec_partial  = {56'd0, it.in_byte};
            dec_in_field = 1'b1;
            dec_left     = 3'(len - 4'd1);
        end else begin
            dec_partial = {dec_partial[55:0], it.in_byte};
            dec_left    = dec_left - 3'd1;
        end
        if (dec_left == 3'd0) begin
            p            = dec_partial;
            dec_in_field = 1'b0;
            done         = 1'b1;
            case (dec_kind)
                sifd_pkg::KIND_U8:  v = {56'd0, p[7:0]};
                sifd_pkg::KIND_S8:  v = {{56{p[7]}}, p[7:0]};
                sifd_pkg::KIND_U16: v = {48'd0, p[15:0]};
                sifd_pkg::KIND_S16: v = {{48{p[15]}}, p[15:0]};
                sifd_pkg::KIND_U24: v = {40'd0, p[23:0]};
                sifd_pkg::KIND_S32: v = {{32{p[31]}}, p[31:0]};
                sifd_pkg::KIND_S64: v = p;
                sifd_pkg::KIND_SSMART:
                    v = (p >= sifd_pkg::SMART_BIAS) ? p - sifd_pkg::SMART_BIAS : p;
                sifd_pkg::KIND_BSMART: begin
                    if (p >= sifd_pkg::BIG_THRESH)
                        v = {33'd0, p[30:0]};
                    else
                        v = (p == 64'(sifd_pkg::RUN_MARK)) ? '1 : p;
                end
                default: begin
                    s = (p >= sifd_pkg::SMART_BIAS) ?
                        p[31:0] - sifd_pkg::SMART_BIAS[31:0] : p[31:0];
                    t = dec_sum + s;
                    if (t > sifd_pkg::SUM_MAX) begin
                        t           = sifd_pkg::SUM_MAX;
                        dec_clamped = 1'b1;
                    end
                    dec_sum = t;
                    // a run mark keeps the field open for the next short smart
                    if (s == sifd_pkg::RUN_MARK) begin
                        dec_in_field = 1'b1;
                        done         = 1'b0;
                    end
                    v = {32'd0, t};
                end
            endcase
            res.value     = v;
            res.saturated = (dec_kind == sifd_pkg::KIND_XSMART) ? dec_clamped : 1'b0;
        end
    endtask

    // Offer one byte, hold it until the transfer, then record what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic [3:0] m,
                             input bit typed, input sifd_pkg::t_out_item typed_res);
        sifd_pkg::t_in_item  it;
        bit                  done;
        sifd_pkg::t_out_item res;
        it.in_byte = b;
        it.mode    = m;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_ready !== 1'b1);
        advance_decoder(it, done, res);
        if (typed)
            expected_fields.push_back(typed_res);
        else if (done)
            expected_fields.push_back(res);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h7f;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic [3:0] m,
                                    input bit typed, input logic [63:0] v,
                                    input bit sat);
        t_dir_row r;
        r.b     = b;
        r.m     = m;
        r.typed = typed;
        r.v     = v;
        r.sat   = sat;
        dir_rows.push_back(r);
    endfunction

    task automatic close_field();
        while (dec_in_field)
            send_byte(pick_byte(), 4'($urandom_range(0, 15)), 1'b0, '0);
    endtask

    // Extended smart field: marks of 0xffff, then one byte that starts the closing value.
    task automatic send_mark_run(input int marks, input logic [7:0] last);
        close_field();
        send_byte(8'hff, sifd_pkg::KIND_XSMART, 1'b0, '0);
        send_byte(8'hff, 4'($urandom_range(0, 15)), 1'b0, '0);
        repeat (marks - 1) begin
            send_byte(8'hff, 4'($urandom_range(0, 15)), 1'b0, '0);
            send_byte(8'hff, 4'($urandom_range(0, 15)), 1'b0, '0);
        end
        send_byte(last, 4'($urandom_range(0, 15)), 1'b0, '0);
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = bytes_sent + count;
        while (bytes_sent < stop) begin
            if (!dec_in_field && $urandom_range(0, 9) == 0)
                send_mark_run(int'($urandom_range(1, 4)), pick_byte());
            else
                send_byte(pick_byte(), 4'($urandom_range(0, 15)), 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        sifd_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_fields.size() == 0) begin
                report_mismatch("field with nothing expected", out_item.value, '0);
            end else begin
                want = expected_fields.pop_front();
                if (out_item.value !== want.value)
                    report_mismatch("value", out_item.value, want.value);
                if (out_item.saturated !== want.saturated)
                    report_mismatch("saturated", 64'(out_item.saturated),
                                    64'(want.saturated));
            end
            fields_seen++;
            if (out_item.saturated === 1'b1)
                clamped_seen++;
        end
    end

    initial begin
        sifd_pkg::t_out_item typed_res;

        add_row(8'hff, sifd_pkg::KIND_U8,     1'b1, 64'd255, 1'b0);
        add_row(8'h80, sifd_pkg::KIND_S8,     1'b1, 64'hffff_ffff_ffff_ff80, 1'b0);
        // unused mode decodes as u8
        add_row(8'h81, 4'd15,                 1'b1, 64'd129, 1'b0);
        add_row(8'h80, sifd_pkg::KIND_S16,    1'b0, 64'd0, 1'b0);
        // mode inside a field is ignored
        add_row(8'h00, sifd_pkg::KIND_S64,    1'b1, 64'hffff_ffff_ffff_8000, 1'b0);
        add_row(8'h80, sifd_pkg::KIND_S32,    1'b0, 64'd0, 1'b0);
        add_row(8'h00, sifd_pkg::KIND_U8,     1'b0, 64'd0, 1'b0);
        add_row(8'h00, sifd_pkg::KIND_U8,     1'b0, 64'd0, 1'b0);
        add_row(8'h00, sifd_pkg::KIND_U8,     1'b1, 64'hffff_ffff_8000_0000, 1'b0);
        add_row(8'h7f, sifd_pkg::KIND_S64,    1'b0, 64'd0, 1'b0);
        repeat (6) add_row(8'hff, sifd_pkg::KIND_U8, 1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_U8,     1'b1, 64'h7fff_ffff_ffff_ffff, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_SSMART, 1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_SSMART, 1'b1, 64'd32767, 1'b0);
        add_row(8'h7f, sifd_pkg::KIND_BSMART, 1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_BSMART, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_BSMART, 1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_U8,     1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_U8,     1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_U8,     1'b1, 64'h7fff_ffff, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_XSMART, 1'b0, 64'd0, 1'b0);
        add_row(8'hff, sifd_pkg::KIND_U8,     1'b0, 64'd0, 1'b0);
        add_row(8'h01, sifd_pkg::KIND_U8,     1'b1, 64'd32768, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 50;
        foreach (dir_rows[i]) begin
            typed_res.value     = dir_rows[i].v;
            typed_res.saturated = dir_rows[i].sat;
            send_byte(dir_rows[i].b, dir_rows[i].m, dir_rows[i].typed, typed_res);
        end
        run_random(460);

        send_idle_pct = 50;
        recv_idle_pct = 33;
        run_random(460);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // stall the output while the input keeps coming, so the block backs up
        hold_req = 1'b1;
        run_random(460);
        close_field();

        in_valid <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes over all ten field kinds and unused modes, checked %0d fields",
                 bytes_sent, fields_seen);
        $display("%0d fields came with a clamped extended sum; output held off for %0d cycles",
                 clamped_seen, HOLD_CYCLES);
        if (mismatches == 0)
            $display("smart_integer_field_decoder_unit: match");
        else
            $display("smart_integer_field_decoder_unit: mismatch");
        $finish;
    end

endmodule

### files.f
hw/rtl/sifd_pkg.sv
hw/rtl/sifd_step.sv
hw/rtl/smart_integer_field_decoder_unit.sv
tb/tb_smart_integer_field_decoder_unit.sv
